// File: design/msd_pkg.sv
// Shared types, constants and the coefficient table of the stereo downmix.
// Used by every module of the block; depends on nothing.

package msd_pkg;

   // Field widths fixed by the item formats
   localparam int SAMPLE_WIDTH = 16;
   localparam int COEF_W       = 16;
   localparam int ACC_W        = 32;
   localparam int FRAC_W       = 15;
   localparam int CHAN_W       = 3;
   localparam int COUNT_W      = 4;
   localparam int SKIP_W       = 16;
   localparam int CSR_DATA_W   = 16;
   localparam int CSR_INDEX_W  = 2;

   // Defaults for the top-level parameters
   localparam int MAX_CHANNELS_DEFAULT = 8;
   localparam int QUEUE_DEPTH_DEFAULT  = 4;

   // Register indexes
   typedef logic [CSR_INDEX_W-1:0] csr_index_type;
   localparam csr_index_type CSR_CHANNEL_COUNT = 2'd0;
   localparam csr_index_type CSR_DOWNMIX_EN    = 2'd1;
   localparam csr_index_type CSR_PRE_SKIP      = 2'd2;

   localparam logic [COUNT_W-1:0] CHANNEL_COUNT_RESET = 4'd2;

   // Input item
   typedef struct packed {
      logic signed [SAMPLE_WIDTH-1:0] sample_in;
      logic                           packet_last;
   } msd_req_type;

   // Result item
   typedef struct packed {
      logic signed [SAMPLE_WIDTH-1:0] sample_out;
      logic [CHAN_W-1:0]              out_channel;
      logic                           frame_last;
      logic                           packet_end;
   } msd_rsp_type;

   // What the back end does with one queued item
   typedef enum logic [1:0] {
      OP_PASS,   // one result, sample as is
      OP_DUP,    // mono to stereo: two copies
      OP_MIX     // matrix accumulate, two results at frame end
   } op_kind_type;

   typedef struct packed {
      logic [COEF_W-1:0] left;
      logic [COEF_W-1:0] right;
   } coef_pair_type;

   // Queue entry between front and back
   typedef struct packed {
      op_kind_type                    kind;
      logic signed [SAMPLE_WIDTH-1:0] sample;
      logic [CHAN_W-1:0]              pos;
      logic                           last;
      logic                           pkt;
      coef_pair_type                  coef;
   } msd_op_type;

   // Back end status, watched at the top level
   typedef struct packed {
      logic out_load;
      logic s1_valid;
      logic s2_valid;
   } msd_back_status_type;

   // Q0.15 mix coefficients; layout is channel count minus three
   function automatic coef_pair_type mix_coef(input logic [2:0] layout,
                                              input logic [2:0] chan);
      coef_pair_type c;
      c = '{left: 16'd0, right: 16'd0};
      case (layout)
         3'd0: begin
            case (chan)
               3'd0: c = '{left: 16'd19195, right: 16'd0};
               3'd1: c = '{left: 16'd13573, right: 16'd13573};
               3'd2: c = '{left: 16'd0,     right: 16'd19195};
               default: c = '{left: 16'd0,  right: 16'd0};
            endcase
         end
         3'd1: begin
            case (chan)
               3'd0: c = '{left: 16'd13848, right: 16'd0};
               3'd1: c = '{left: 16'd0,     right: 16'd13848};
               3'd2: c = '{left: 16'd11993, right: 16'd6927};
               3'd3: c = '{left: 16'd6927,  right: 16'd11010};
               default: c = '{left: 16'd0,  right: 16'd0};
            endcase
         end
         3'd2: begin
            case (chan)
               3'd0: c = '{left: 16'd21332, right: 16'd0};
               3'd1: c = '{left: 16'd15073, right: 16'd15073};
               3'd2: c = '{left: 16'd0,     right: 16'd21332};
               3'd3: c = '{left: 16'd18468, right: 16'd10663};
               3'd4: c = '{left: 16'd10663, right: 16'd18468};
               default: c = '{left: 16'd0,  right: 16'd0};
            endcase
         end
         3'd3: begin
            case (chan)
               3'd0: c = '{left: 16'd17334, right: 16'd0};
               3'd1: c = '{left: 16'd12259, right: 16'd12259};
               3'd2: c = '{left: 16'd0,     right: 16'd17334};
               3'd3: c = '{left: 16'd15014, right: 16'd8667};
               3'd4: c = '{left: 16'd8667,  right: 16'd15014};
               3'd5: c = '{left: 16'd12259, right: 16'd12259};
               default: c = '{left: 16'd0,  right: 16'd0};
            endcase
         end
         3'd4: begin
            case (chan)
               3'd0: c = '{left: 16'd14919, right: 16'd0};
               3'd1: c = '{left: 16'd10551, right: 16'd10551};
               3'd2: c = '{left: 16'd0,     right: 16'd14919};
               3'd3: c = '{left: 16'd12920, right: 16'd7461};
               3'd4: c = '{left: 16'd7461,  right: 16'd12920};
               3'd5: c = '{left: 16'd9136,  right: 16'd9136};
               3'd6: c = '{left: 16'd10551, right: 16'd10551};
               default: c = '{left: 16'd0,  right: 16'd0};
            endcase
         end
         3'd5: begin
            case (chan)
               3'd0: c = '{left: 16'd12734, right: 16'd0};
               3'd1: c = '{left: 16'd9005,  right: 16'd9005};
               3'd2: c = '{left: 16'd0,     right: 16'd12734};
               3'd3: c = '{left: 16'd11030, right: 16'd6367};
               3'd4: c = '{left: 16'd6367,  right: 16'd11030};
               3'd5: c = '{left: 16'd11030, right: 16'd6367};
               3'd6: c = '{left: 16'd6367,  right: 16'd11030};
               default: c = '{left: 16'd9005, right: 16'd9005};
            endcase
         end
         default: c = '{left: 16'd0, right: 16'd0};
      endcase
      return c;
   endfunction

endpackage

// File: design/msd_queue.sv
// Small FIFO of decoded ops between the front and back ends.
// Depends on msd_pkg for the entry type.

module msd_queue
   import msd_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  msd_op_type push_data,
   output logic       full,
   input  logic       pop,
   output msd_op_type pop_data,
   output logic       empty
);

   localparam int PTR_W = $clog2(DEPTH);

   msd_op_type       mem_ff [DEPTH];
   logic [PTR_W:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W:0]   rd_ptr_ff, rd_ptr_in;

   // Pointers carry one extra wrap bit
   assign empty = (wr_ptr_ff == rd_ptr_ff);
   assign full  = (wr_ptr_ff[PTR_W-1:0] == rd_ptr_ff[PTR_W-1:0]) &&
                  (wr_ptr_ff[PTR_W] != rd_ptr_ff[PTR_W]);
   assign pop_data = mem_ff[rd_ptr_ff[PTR_W-1:0]];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push && !full) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop && !empty) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   // Entry storage, no reset
   always_ff @(posedge clock) begin
      if (push && !full) begin
         mem_ff[wr_ptr_ff[PTR_W-1:0]] <= push_data;
      end
   end

endmodule

// File: design/msd_front.sv
// Front end: configuration registers, frame position and skip tracking,
// classification of each item into a queued op. Depends on msd_pkg.

module msd_front
   import msd_pkg::*;
#(
   parameter int MAX_CHANNELS = MAX_CHANNELS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   input  csr_index_type         csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   input  logic                  req_push,
   input  msd_req_type           req_data,
   input  logic                  q_full,
   output logic                  q_push,
   output msd_op_type            q_data
);

   localparam int POS_W = $clog2(MAX_CHANNELS);
   localparam logic [COUNT_W-1:0] MAX_N = COUNT_W'(MAX_CHANNELS);

   logic [COUNT_W-1:0] count_ff, count_in;
   logic               force_ff, force_in;
   logic [SKIP_W-1:0]  skip_ff, skip_in;
   logic [POS_W-1:0]   pos_ff, pos_in;

   logic [COUNT_W-1:0] n;
   logic [POS_W-1:0]   pos;
   logic               last;
   logic               accept;
   op_kind_type        kind;
   logic [2:0]         layout;

   // Effective channel count and position
   always_comb begin
      if (count_ff == '0) begin
         n = COUNT_W'(1);
      end else if (count_ff > MAX_N) begin
         n = MAX_N;
      end else begin
         n = count_ff;
      end
      pos    = (COUNT_W'(pos_ff) >= n) ? '0 : pos_ff;
      last   = ((COUNT_W'(pos) + COUNT_W'(1)) == n);
      layout = 3'(n - COUNT_W'(3));
   end

   // Classify
   always_comb begin
      if (!force_ff || n == COUNT_W'(2)) begin
         kind = OP_PASS;
      end else if (n == COUNT_W'(1)) begin
         kind = OP_DUP;
      end else begin
         kind = OP_MIX;
      end
   end

   assign accept = req_push && !q_full;
   assign q_push = accept && (skip_ff == '0);

   always_comb begin
      q_data.kind   = kind;
      q_data.sample = req_data.sample_in;
      q_data.pos    = CHAN_W'(pos);
      q_data.last   = last;
      q_data.pkt    = req_data.packet_last;
      q_data.coef   = mix_coef(layout, CHAN_W'(pos));
   end

   // Position, skip count and register writes
   always_comb begin
      count_in = count_ff;
      force_in = force_ff;
      skip_in  = skip_ff;
      pos_in   = pos_ff;
      if (accept) begin
         pos_in = last ? '0 : POS_W'(pos + 1'b1);
         if (skip_ff != '0 && last) begin
            skip_in = skip_ff - 1'b1;
         end
      end
      if (csr_valid) begin
         unique case (csr_index)
            CSR_CHANNEL_COUNT: begin
               count_in = csr_data[COUNT_W-1:0];
               pos_in   = '0;
            end
            CSR_DOWNMIX_EN: begin
               force_in = csr_data[0];
               pos_in   = '0;
            end
            CSR_PRE_SKIP: begin
               skip_in = csr_data[SKIP_W-1:0];
            end
            default: begin
               count_in = count_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= CHANNEL_COUNT_RESET;
         force_ff <= 1'b0;
         skip_ff  <= '0;
         pos_ff   <= '0;
      end else begin
         count_ff <= count_in;
         force_ff <= force_in;
         skip_ff  <= skip_in;
         pos_ff   <= pos_in;
      end
   end

endmodule

// File: design/msd_back.sv
// Back end: multiply stage, saturating accumulate stage and the result
// emitter with its output register. Depends on msd_pkg.

module msd_back
   import msd_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                q_empty,
   input  msd_op_type          q_data,
   output logic                q_pop,
   input  logic                rsp_pop,
   output logic                rsp_empty,
   output msd_rsp_type         rsp_data,
   output msd_back_status_type status
);

   localparam int PROD_W = SAMPLE_WIDTH + COEF_W;
   localparam int SUM_W  = ((PROD_W > ACC_W) ? PROD_W : ACC_W) + 1;
   localparam int RND_W  = ACC_W + 1;
   localparam int Q_W    = RND_W - FRAC_W;

   localparam logic signed [SUM_W-1:0] ACC_MAX =
      {{(SUM_W-ACC_W+1){1'b0}}, {(ACC_W-1){1'b1}}};
   localparam logic signed [SUM_W-1:0] ACC_MIN =
      {{(SUM_W-ACC_W+1){1'b1}}, {(ACC_W-1){1'b0}}};
   localparam logic signed [RND_W-1:0] HALF = RND_W'(1 << (FRAC_W - 1));
   localparam logic signed [Q_W-1:0] SMP_MAX =
      {{(Q_W-SAMPLE_WIDTH+1){1'b0}}, {(SAMPLE_WIDTH-1){1'b1}}};
   localparam logic signed [Q_W-1:0] SMP_MIN =
      {{(Q_W-SAMPLE_WIDTH+1){1'b1}}, {(SAMPLE_WIDTH-1){1'b0}}};

   // Stage 1: products
   logic                     s1_valid_ff, s1_valid_in;
   msd_op_type               s1_op_ff;
   logic signed [PROD_W-1:0] prod_l_ff, prod_r_ff;
   logic signed [PROD_W-1:0] prod_l, prod_r;

   // Stage 2: accumulators and pending results
   logic                     s2_valid_ff, s2_valid_in;
   msd_op_type               s2_op_ff;
   logic signed [ACC_W-1:0]  acc_l_ff, acc_r_ff;
   logic                     phase_ff, phase_in;

   // Output register
   logic                     out_valid_ff, out_valid_in;
   msd_rsp_type              out_ff, out_in;

   logic adv1, adv2, s2_done, out_free, out_load, two, none, load_acc;
   logic signed [SAMPLE_WIDTH-1:0] rnd_l, rnd_r;
   logic signed [ACC_W-1:0]  sum_l, sum_r;

   // Saturating add to the accumulator range
   function automatic logic signed [ACC_W-1:0] sat_add(
      input logic signed [ACC_W-1:0]  a,
      input logic signed [PROD_W-1:0] b);
      logic signed [SUM_W-1:0] t;
      t = SUM_W'(a) + SUM_W'(b);
      if (t > ACC_MAX) begin
         t = ACC_MAX;
      end else if (t < ACC_MIN) begin
         t = ACC_MIN;
      end
      return t[ACC_W-1:0];
   endfunction

   // Round half up to Q1.15 and saturate to the sample range
   function automatic logic signed [SAMPLE_WIDTH-1:0] round_sat(
      input logic signed [ACC_W-1:0] a);
      logic signed [RND_W-1:0] t;
      logic signed [Q_W-1:0]   q;
      t = RND_W'(a) + HALF;
      q = t[RND_W-1:FRAC_W];
      if (q > SMP_MAX) begin
         q = SMP_MAX;
      end else if (q < SMP_MIN) begin
         q = SMP_MIN;
      end
      return q[SAMPLE_WIDTH-1:0];
   endfunction

   assign prod_l = q_data.sample * $signed(q_data.coef.left);
   assign prod_r = q_data.sample * $signed(q_data.coef.right);

   // Emitter control
   always_comb begin
      two      = (s2_op_ff.kind == OP_DUP) || (s2_op_ff.kind == OP_MIX && s2_op_ff.last);
      none     = (s2_op_ff.kind == OP_MIX) && !s2_op_ff.last;
      out_free = !out_valid_ff || rsp_pop;
      out_load = s2_valid_ff && !none && out_free;
      s2_done  = s2_valid_ff && (none || (out_free && (!two || phase_ff)));
      adv2     = !s2_valid_ff || s2_done;
      adv1     = !s1_valid_ff || adv2;
      q_pop    = adv1 && !q_empty;
      load_acc = adv2 && s1_valid_ff && (s1_op_ff.kind == OP_MIX);
   end

   // Accumulate; a frame start ignores the old sums
   always_comb begin
      sum_l = sat_add((s1_op_ff.pos == '0) ? '0 : acc_l_ff, prod_l_ff);
      sum_r = sat_add((s1_op_ff.pos == '0) ? '0 : acc_r_ff, prod_r_ff);
      rnd_l = round_sat(acc_l_ff);
      rnd_r = round_sat(acc_r_ff);
   end

   // Result selection
   always_comb begin
      out_in = out_ff;
      if (!two) begin
         out_in.sample_out  = s2_op_ff.sample;
         out_in.out_channel = s2_op_ff.pos;
         out_in.frame_last  = s2_op_ff.last;
         out_in.packet_end  = s2_op_ff.pkt;
      end else if (!phase_ff) begin
         out_in.sample_out  = (s2_op_ff.kind == OP_MIX) ? rnd_l : s2_op_ff.sample;
         out_in.out_channel = CHAN_W'(0);
         out_in.frame_last  = 1'b0;
         out_in.packet_end  = 1'b0;
      end else begin
         out_in.sample_out  = (s2_op_ff.kind == OP_MIX) ? rnd_r : s2_op_ff.sample;
         out_in.out_channel = CHAN_W'(1);
         out_in.frame_last  = 1'b1;
         out_in.packet_end  = s2_op_ff.pkt;
      end
   end

   // Control next state
   always_comb begin
      s1_valid_in  = adv1 ? !q_empty : s1_valid_ff;
      s2_valid_in  = adv2 ? s1_valid_ff : s2_valid_ff;
      phase_in     = phase_ff;
      if (s2_done) begin
         phase_in = 1'b0;
      end else if (out_load && two) begin
         phase_in = 1'b1;
      end
      out_valid_in = out_load ? 1'b1 : (rsp_pop ? 1'b0 : out_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         phase_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         phase_ff     <= phase_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Datapath registers, no reset
   always_ff @(posedge clock) begin
      if (adv1) begin
         s1_op_ff  <= q_data;
         prod_l_ff <= prod_l;
         prod_r_ff <= prod_r;
      end
      if (adv2) begin
         s2_op_ff <= s1_op_ff;
      end
      if (load_acc) begin
         acc_l_ff <= sum_l;
         acc_r_ff <= sum_r;
      end
      if (out_load) begin
         out_ff <= out_in;
      end
   end

   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_ff;

   assign status.out_load = out_load;
   assign status.s1_valid = s1_valid_ff;
   assign status.s2_valid = s2_valid_ff;

endmodule

// File: design/multichannel_stereo_downmix.sv
// Top level of the surround-to-stereo downmix: front end, op queue, back end.
// Depends on msd_pkg, msd_front, msd_queue and msd_back.
//
// Usage:
// - Input is a queue port: one interleaved PCM sample per item on req_data,
//   taken when req_push is high and req_full is low.
// - Results are a queue port: the oldest result sits on rsp_data while
//   rsp_empty is low and leaves when rsp_pop is high.
// - Registers (channel count, stereo downmix enable, pre-skip frames) are
//   written over csr_valid/csr_ready with csr_index and csr_data; csr_ready
//   is always high. Write them only while no item is in flight.
// - Path: an item once taken passes through the queue, the multiply stage and
//   the accumulate stage to the output register, which drives rsp_data.
// - Throughput: one item per cycle while req_full is low. The output register
//   hands out one result per cycle, so an item giving a left/right pair (mono
//   copy, end of a mixed frame) holds the back end until both are loaded; the
//   op queue absorbs it. Skipped frames and mid-frame mixed samples give no result.
// - Reset: synchronous; empties the queue and pipeline, channel count goes to
//   2, downmix enable and the skip count to 0.
// - When the receiver stops popping, the output register holds its result,
//   the back end stops, the queue fills and req_full rises.

module multichannel_stereo_downmix
   import msd_pkg::*;
#(
   parameter int MAX_CHANNELS = MAX_CHANNELS_DEFAULT,
   parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   output logic                  req_full,
   input  msd_req_type           req_data,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output msd_rsp_type           rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  csr_index_type         csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   logic                q_push, q_pop, q_full, q_empty;
   msd_op_type          q_in, q_out;
   msd_back_status_type back_status;

   assign csr_ready = 1'b1;
   assign req_full  = q_full;

   msd_front #(
      .MAX_CHANNELS(MAX_CHANNELS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .csr_valid(csr_valid && csr_ready),
      .csr_index(csr_index),
      .csr_data (csr_data),
      .req_push (req_push),
      .req_data (req_data),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_data   (q_in)
   );

   msd_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_data(q_in),
      .full     (q_full),
      .pop      (q_pop),
      .pop_data (q_out),
      .empty    (q_empty)
   );

   msd_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_empty  (q_empty),
      .q_data   (q_out),
      .q_pop    (q_pop),
      .rsp_pop  (rsp_pop),
      .rsp_empty(rsp_empty),
      .rsp_data (rsp_data),
      .status   (back_status)
   );

   // Reset leaves nothing to deliver and room for input
   a_reset_clean: assert property (@(posedge clock)
      reset |=> (rsp_empty && !req_full && !back_status.s1_valid && !back_status.s2_valid))
      else $error("state not cleared after reset");

   // A new result never overwrites one still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      back_status.out_load |-> (rsp_empty || rsp_pop))
      else $error("output register overwritten");

   // The back end only pulls ops that exist
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("op queue popped while empty");

   // A loaded result is visible in the next cycle
   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      back_status.out_load |=> !rsp_empty)
      else $error("loaded result not presented");

endmodule

// File: tb/tb_multichannel_stereo_downmix.sv
// Self-checking testbench for the surround-to-stereo downmix block.
// Depends on msd_pkg and multichannel_stereo_downmix; predicts every result
// in-line and checks it as the block pops it out.
`timescale 1ns / 1ps

module tb_multichannel_stereo_downmix;
   import msd_pkg::*;

   localparam csr_index_type CSR_UNUSED = 2'd3;  // no register behind it
   localparam int DRAIN_PAUSE  = 12;             // cycles after the last result
   localparam int RANDOM_PHASES = 12;
   localparam int PHASE_ITEMS   = 170;

   // Q0.15 mix coefficients, [channels - 3][channel]
   int mix_left [6][8] = '{
      '{19195, 13573, 0,     0,     0,     0,     0,     0},
      '{13848, 0,     11993, 6927,  0,     0,     0,     0},
      '{21332, 15073, 0,     18468, 10663, 0,     0,     0},
      '{17334, 12259, 0,     15014, 8667,  12259, 0,     0},
      '{14919, 10551, 0,     12920, 7461,  9136,  10551, 0},
      '{12734, 9005,  0,     11030, 6367,  11030, 6367,  9005}
   };
   int mix_right [6][8] = '{
      '{0, 13573, 19195, 0,     0,     0,     0,     0},
      '{0, 13848, 6927,  11010, 0,     0,     0,     0},
      '{0, 15073, 21332, 10663, 18468, 0,     0,     0},
      '{0, 12259, 17334, 8667,  15014, 12259, 0,     0},
      '{0, 10551, 14919, 7461,  12920, 9136,  10551, 0},
      '{0, 9005,  12734, 6367,  11030, 6367,  11030, 9005}
   };

   logic                  clock;
   logic                  reset     = 1'b1;
   logic                  req_push  = 1'b0;
   logic                  req_full;
   msd_req_type           req_data  = '0;
   logic                  rsp_empty;
   logic                  rsp_pop   = 1'b0;
   msd_rsp_type           rsp_data;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   csr_index_type         csr_index = CSR_CHANNEL_COUNT;
   logic [CSR_DATA_W-1:0] csr_data  = '0;

   // Stimulus backlog and expected outputs
   msd_req_type queued_samples [$];
   msd_rsp_type expected_outputs [$];
   int          mismatch_count = 0;
   int          send_idle_pct  = 25;
   int          recv_idle_pct  = 69;

   // Shadow of the block's registers and frame state
   logic [3:0]         shadow_chan_count = 4'd2;
   logic               shadow_force      = 1'b0;
   logic [SKIP_W-1:0]  shadow_skip       = '0;
   logic [2:0]         shadow_pos        = '0;
   longint             shadow_acc_l      = 0;
   longint             shadow_acc_r      = 0;

   multichannel_stereo_downmix dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // 32-bit saturating accumulator
   function automatic longint clamp_acc(input longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   // Q2.30 sum back to Q1.15, half rounds up, saturated to 16 bits
   function automatic longint round_to_sample(input longint acc);
      longint q;
      q = (acc + 16384) >>> 15;
      if (q > 32767) q = 32767;
      if (q < -32768) q = -32768;
      return q;
   endfunction

   // Works out the results of one accepted item and queues them
   function automatic void downmix_predict(input msd_req_type item);
      int          n;
      int          pos;
      bit          at_end;
      longint      s;
      int          produced;
      msd_rsp_type first_res;
      msd_rsp_type last_res;
      n = int'(shadow_chan_count);
      if (n < 1) n = 1;
      if (n > 8) n = 8;
      pos = int'(shadow_pos);
      if (pos >= n) pos = 0;
      at_end = (pos + 1 == n);
      s = longint'(item.sample_in);
      produced = 0;
      first_res = '0;
      last_res = '0;
      if (shadow_skip != 0) begin
         if (at_end) shadow_skip = shadow_skip - 1'b1;
      end else if (!shadow_force || n == 2) begin
         last_res = '{sample_out: s[15:0], out_channel: pos[2:0],
                      frame_last: at_end, packet_end: 1'b0};
         produced = 1;
      end else if (n == 1) begin
         first_res = '{sample_out: s[15:0], out_channel: 3'd0,
                       frame_last: 1'b0, packet_end: 1'b0};
         last_res = '{sample_out: s[15:0], out_channel: 3'd1,
                      frame_last: 1'b1, packet_end: 1'b0};
         produced = 2;
      end else begin
         longint l;
         longint r;
         longint lq;
         longint rq;
         l = clamp_acc((pos == 0 ? 0 : shadow_acc_l) + s * mix_left[n-3][pos]);
         r = clamp_acc((pos == 0 ? 0 : shadow_acc_r) + s * mix_right[n-3][pos]);
         shadow_acc_l = l;
         shadow_acc_r = r;
         if (at_end) begin
            lq = round_to_sample(l);
            rq = round_to_sample(r);
            first_res = '{sample_out: lq[15:0], out_channel: 3'd0,
                          frame_last: 1'b0, packet_end: 1'b0};
            last_res = '{sample_out: rq[15:0], out_channel: 3'd1,
                         frame_last: 1'b1, packet_end: 1'b0};
            produced = 2;
            shadow_acc_l = 0;
            shadow_acc_r = 0;
         end
      end
      if (produced == 2) expected_outputs.push_back(first_res);
      if (produced > 0) begin
         last_res.packet_end = item.packet_last;
         expected_outputs.push_back(last_res);
      end
      shadow_pos = at_end ? 3'd0 : 3'(pos + 1);
   endfunction

   // Mirror a register write into the shadow state
   function automatic void shadow_write(input csr_index_type idx,
                                        input logic [CSR_DATA_W-1:0] val);
      case (idx)
         CSR_CHANNEL_COUNT: begin
            shadow_chan_count = val[3:0];
            shadow_pos = '0;
            shadow_acc_l = 0;
            shadow_acc_r = 0;
         end
         CSR_DOWNMIX_EN: begin
            shadow_force = val[0];
            shadow_pos = '0;
            shadow_acc_l = 0;
            shadow_acc_r = 0;
         end
         CSR_PRE_SKIP: shadow_skip = val;
         default: ;
      endcase
   endfunction

   task automatic csr_write(input csr_index_type idx, input logic [CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      shadow_write(idx, val);
   endtask

   // Wait until all items are taken and all results are back, then let the
   // pipeline flush items that give no result
   task automatic settle_idle();
      while (queued_samples.size() > 0 || expected_outputs.size() > 0 || req_push)
         @(posedge clock);
      repeat (DRAIN_PAUSE) @(posedge clock);
   endtask

   task automatic queue_sample(input logic [15:0] v, input logic pkt);
      msd_req_type it;
      it.sample_in   = v;
      it.packet_last = pkt;
      queued_samples.push_back(it);
   endtask

   // Random sample: extremes now and then, packet marks now and then
   task automatic queue_random_sample();
      logic [15:0] v;
      case ($urandom_range(0, 7))
         0: v = 16'h7FFF;
         1: v = 16'h8000;
         default: v = 16'($urandom);
      endcase
      queue_sample(v, ($urandom_range(0, 7) == 0));
   endtask

   // Input side: present queued samples, predict on acceptance
   always @(posedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
      end else begin
         if (req_push && !req_full) begin
            downmix_predict(req_data);
            void'(queued_samples.pop_front());
         end
         if (req_push && req_full) begin
            // hold the item until taken
         end else if (queued_samples.size() > 0 &&
                      $urandom_range(0, 99) >= send_idle_pct) begin
            req_push <= 1'b1;
            req_data <= queued_samples[0];
         end else begin
            req_push <= 1'b0;
         end
      end
   end

   // Output side: random pops, each popped result checked against the oldest
   always @(posedge clock) begin : result_check
      msd_rsp_type want;
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (expected_outputs.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected result: sample %0d chan %0d frame_last %0b pkt %0b",
                           rsp_data.sample_out, rsp_data.out_channel,
                           rsp_data.frame_last, rsp_data.packet_end);
            end else begin
               want = expected_outputs.pop_front();
               if (rsp_data.sample_out !== want.sample_out ||
                   rsp_data.out_channel !== want.out_channel ||
                   rsp_data.frame_last !== want.frame_last ||
                   rsp_data.packet_end !== want.packet_end) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display({"mismatch at %0t: sample exp %0d got %0d, ",
                               "chan exp %0d got %0d, frame_last exp %0b got %0b, ",
                               "pkt exp %0b got %0b"},
                              $realtime, want.sample_out, rsp_data.sample_out,
                              want.out_channel, rsp_data.out_channel,
                              want.frame_last, rsp_data.frame_last,
                              want.packet_end, rsp_data.packet_end);
               end
            end
         end
         rsp_pop <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // Main sequence: directed checks, then random phases
   initial begin : stimulus
      int          phase;
      int          k;
      int          chans;
      int          eff_chans;
      logic        stereo;
      int          skip_frames;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: stereo pass-through, field extremes
      queue_sample(16'h7FFF, 1'b1);
      queue_sample(16'h8000, 1'b0);
      settle_idle();

      // Channel count zero acts as mono; mono frames are copied to both sides
      csr_write(CSR_CHANNEL_COUNT, 16'd0);
      csr_write(CSR_DOWNMIX_EN, 16'd1);
      queue_sample(16'h7FFF, 1'b0);
      queue_sample(16'h8000, 1'b1);
      settle_idle();

      // Count above max acts as eight; one frame skipped, then a frame of
      // full-scale negatives saturates both sums; a mid-frame packet mark
      // is dropped; writes to the unused index change nothing
      csr_write(CSR_CHANNEL_COUNT, 16'd15);
      csr_write(CSR_PRE_SKIP, 16'd1);
      csr_write(CSR_UNUSED, 16'hFFFF);
      for (k = 0; k < 8; k++) queue_random_sample();
      for (k = 0; k < 8; k++) queue_sample(16'h8000, (k == 3 || k == 7));
      settle_idle();

      // Rewriting a register mid-frame drops the partial sums
      csr_write(CSR_CHANNEL_COUNT, 16'd3);
      queue_sample(16'h7FFF, 1'b0);
      queue_sample(16'h7FFF, 1'b0);
      settle_idle();
      csr_write(CSR_DOWNMIX_EN, 16'd1);
      queue_sample(16'h1234, 1'b0);
      queue_sample(16'hEDCB, 1'b0);
      queue_sample(16'h4000, 1'b1);
      settle_idle();

      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         if (phase == RANDOM_PHASES / 3) begin
            send_idle_pct = 69;
            recv_idle_pct = 25;
         end else if (phase == 2 * RANDOM_PHASES / 3) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end

         // Longest pre-skip: everything sent is dropped
         if (phase == 5) begin
            csr_write(CSR_PRE_SKIP, 16'hFFFF);
            for (k = 0; k < 20; k++) queue_random_sample();
            settle_idle();
         end

         chans = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 15)
                                              : $urandom_range(1, 8);
         if (phase == 0) chans = 8;
         if (phase == 1) chans = 1;
         eff_chans = (chans < 1) ? 1 : (chans > 8) ? 8 : chans;
         stereo = ($urandom_range(0, 3) != 0) || phase < 2;
         skip_frames = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;

         csr_write(CSR_CHANNEL_COUNT, {12'($urandom), 4'(chans)});
         csr_write(CSR_DOWNMIX_EN, {15'($urandom), stereo});
         csr_write(CSR_PRE_SKIP, 16'(skip_frames));
         for (k = 0; k < PHASE_ITEMS + skip_frames * eff_chans; k++)
            queue_random_sample();
         settle_idle();
      end

      if (mismatch_count == 0 && expected_outputs.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // Hang guard
   initial begin
      #(2_000_000);
      $display("DONE: errors detected");
      $finish;
   end

endmodule

// File: files.f
design/msd_pkg.sv
design/msd_queue.sv
design/msd_front.sv
design/msd_back.sv
design/multichannel_stereo_downmix.sv
tb/tb_multichannel_stereo_downmix.sv
